@@ hw/rtl/tfn_pkg.sv @@
// ---------------------------------------------------------------------------
// tfn_pkg
// Shared widths and types of the triangle face normal pipeline.
// ---------------------------------------------------------------------------
package tfn_pkg;

  localparam int MAG_W   = 31;  // normalized magnitude bits
  localparam int SUMSQ_W = 64;  // sum of squares width
  localparam int ROOT_W  = 32;  // integer square root width
  localparam int QUO_W   = 32;  // quotient width before clamping
  localparam int NORM_W  = 32;  // output component width
  localparam int NORM_FRAC = 30;

  typedef logic [MAG_W-1:0] mag_t;

  // Sideband that travels with each request through the pipeline.
  typedef struct packed {
    logic [2:0] neg;
    logic       degen;
  } side_t;

endpackage

@@ hw/rtl/triangle_face_normal_unit.sv @@
// Throughput: one triangle per cycle while no output stall holds the pipeline.
// Throughput is set by the fully pipelined root and divider stages.
// A stall at the output while a result is valid freezes every stage; nothing is lost or repeated.
// Synchronous active-low reset clears all valid bits; data registers hold.
// ---------------------------------------------------------------------------
// triangle_face_normal_unit
// Unit face normal of a fixed-point triangle, deep pipeline.
// ---------------------------------------------------------------------------
module triangle_face_normal_unit import tfn_pkg::*; #(
  parameter int COORD_WIDTH     = 32,
  parameter int COORD_FRAC_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [COORD_WIDTH-1:0] in_vertex_a_x, in_vertex_a_y, in_vertex_a_z,
  input  logic signed [COORD_WIDTH-1:0] in_vertex_b_x, in_vertex_b_y, in_vertex_b_z,
  input  logic signed [COORD_WIDTH-1:0] in_vertex_c_x, in_vertex_c_y, in_vertex_c_z,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [NORM_W-1:0]      out_normal_x, out_normal_y, out_normal_z,
  output logic                          out_degenerate
);

  // The fraction position cancels out in normalization, so COORD_FRAC_BITS
  // does not reach the datapath.

  logic en;
  logic v1, v2;
  mag_t m0, m1, m2, s0, s1, s2;
  side_t sd1, sd2;
  logic [ROOT_W-1:0] root;
  logic [NORM_W-1:0] n0, n1, n2;

  // Whole pipeline advances unless a finished result is held.
  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  tfn_cross #(.CW(COORD_WIDTH)) u_cross (
    .clk, .rst_n, .en, .vld_in(in_valid),
    .ax(in_vertex_a_x), .ay(in_vertex_a_y), .az(in_vertex_a_z),
    .bx(in_vertex_b_x), .by(in_vertex_b_y), .bz(in_vertex_b_z),
    .cx(in_vertex_c_x), .cy(in_vertex_c_y), .cz(in_vertex_c_z),
    .vld_out(v1), .m0, .m1, .m2, .side_out(sd1)
  );

  tfn_sqrt u_sqrt (
    .clk, .rst_n, .en, .vld_in(v1), .m0_in(m0), .m1_in(m1), .m2_in(m2),
    .side_in(sd1), .vld_out(v2), .m0_out(s0), .m1_out(s1), .m2_out(s2),
    .side_out(sd2), .root
  );

  tfn_div u_div (
    .clk, .rst_n, .en, .vld_in(v2), .m0(s0), .m1(s1), .m2(s2),
    .side_in(sd2), .root, .vld_out(out_valid), .n0, .n1, .n2,
    .degen(out_degenerate)
  );

  assign out_normal_x = n0;
  assign out_normal_y = n1;
  assign out_normal_z = n2;

endmodule

@@ hw/rtl/tfn_cross.sv @@
// ---------------------------------------------------------------------------
// tfn_cross
// Edge vectors, products, cross product magnitudes and normalizing shift, each registered.
// ---------------------------------------------------------------------------
module tfn_cross import tfn_pkg::*; #(
  parameter int CW = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic                 vld_in,
  input  logic signed [CW-1:0] ax, ay, az, bx, by, bz, cx, cy, cz,
  output logic                 vld_out,
  output mag_t                 m0, m1, m2,
  output side_t                side_out
);

  localparam int EW = CW + 1;        // edge width
  localparam int PW = 2 * EW;        // product width
  localparam int XW = PW + 1;        // cross product width
  localparam int LW = $clog2(XW + 1);

  logic signed [EW-1:0] e1x_r, e1y_r, e1z_r, e2x_r, e2y_r, e2z_r;
  logic signed [PW-1:0] p_r [6];
  logic signed [XW-1:0] c [3];
  logic [XW-1:0] mag_r [3];
  logic [2:0] neg_r;
  logic [2:0] v_r;
  logic [XW-1:0] orv;
  logic [LW-1:0] len;
  logic [XW+MAG_W-1:0] ext [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[1:0], vld_in};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      e1x_r <= EW'(bx) - EW'(ax);
      e1y_r <= EW'(by) - EW'(ay);
      e1z_r <= EW'(bz) - EW'(az);
      e2x_r <= EW'(cx) - EW'(ax);
      e2y_r <= EW'(cy) - EW'(ay);
      e2z_r <= EW'(cz) - EW'(az);
      p_r[0] <= e1y_r * e2z_r;
      p_r[1] <= e1z_r * e2y_r;
      p_r[2] <= e1z_r * e2x_r;
      p_r[3] <= e1x_r * e2z_r;
      p_r[4] <= e1x_r * e2y_r;
      p_r[5] <= e1y_r * e2x_r;
      for (int i = 0; i < 3; i++) begin
        neg_r[i] <= c[i][XW-1];
        mag_r[i] <= c[i][XW-1] ? XW'(-c[i]) : XW'(c[i]);
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      c[i] = XW'(p_r[2*i]) - XW'(p_r[2*i+1]);
    end
    orv = mag_r[0] | mag_r[1] | mag_r[2];
    len = '0;
    for (int k = 0; k < XW; k++) begin
      if (orv[k]) len = LW'(k + 1);
    end
    // Place the largest magnitude's top bit at bit MAG_W-1.
    for (int i = 0; i < 3; i++) begin
      ext[i] = {mag_r[i], {MAG_W{1'b0}}} >> len;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_out <= 1'b0;
    end else if (en) begin
      vld_out <= v_r[2];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m0 <= ext[0][MAG_W-1:0];
      m1 <= ext[1][MAG_W-1:0];
      m2 <= ext[2][MAG_W-1:0];
      side_out.neg   <= neg_r;
      side_out.degen <= (orv == '0);
    end
  end

endmodule

@@ hw/rtl/tfn_sqrt.sv @@
// ---------------------------------------------------------------------------
// tfn_sqrt
// Sum of squares and a pipelined restoring square root, one root bit (two radicand bits) per stage.
// ---------------------------------------------------------------------------
module tfn_sqrt import tfn_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               vld_in,
  input  mag_t               m0_in, m1_in, m2_in,
  input  side_t              side_in,
  output logic               vld_out,
  output mag_t               m0_out, m1_out, m2_out,
  output side_t              side_out,
  output logic [ROOT_W-1:0]  root
);

  localparam int STEPS = ROOT_W;
  localparam int NS = STEPS + 2;

  logic [NS-1:0]        v_r;
  logic [2*MAG_W-1:0]   sq_r [3];
  mag_t                 m_r  [NS][3];
  side_t                sd_r [NS];
  logic [SUMSQ_W-1:0]   rem_r [1:NS-1];
  logic [ROOT_W-1:0]    res_r [1:NS-1];
  logic [SUMSQ_W+1:0]   trial [STEPS];

  function automatic mag_t m_sel(input int i);
    unique case (i)
      0:       return m0_in;
      1:       return m1_in;
      default: return m2_in;
    endcase
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[NS-2:0], vld_in};
    end
  end

  // Each stage decides one root bit from the top of the remainder.
  always_comb begin
    for (int s = 0; s < STEPS; s++) begin
      trial[s] = ({2'b00, rem_r[s+1] >> (2 * (STEPS - 1 - s))})
                 - {{(SUMSQ_W-ROOT_W){1'b0}}, res_r[s+1], 2'b01};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        sq_r[i] <= m_sel(i) * m_sel(i);
        m_r[0][i] <= m_sel(i);
      end
      sd_r[0] <= side_in;
      rem_r[1] <= SUMSQ_W'(sq_r[0]) + SUMSQ_W'(sq_r[1]) + SUMSQ_W'(sq_r[2]);
      res_r[1] <= '0;
      m_r[1] <= m_r[0];
      sd_r[1] <= sd_r[0];
      for (int s = 0; s < STEPS; s++) begin
        m_r[s+2] <= m_r[s+1];
        sd_r[s+2] <= sd_r[s+1];
        if (!trial[s][SUMSQ_W+1]) begin
          rem_r[s+2] <= rem_r[s+1]
                      - (SUMSQ_W'({res_r[s+1], 2'b01}) << (2 * (STEPS - 1 - s)));
          res_r[s+2] <= {res_r[s+1][ROOT_W-2:0], 1'b1};
        end else begin
          rem_r[s+2] <= rem_r[s+1];
          res_r[s+2] <= {res_r[s+1][ROOT_W-2:0], 1'b0};
        end
      end
    end
  end

  assign vld_out  = v_r[NS-1];
  assign m0_out   = m_r[NS-1][0];
  assign m1_out   = m_r[NS-1][1];
  assign m2_out   = m_r[NS-1][2];
  assign side_out = sd_r[NS-1];
  assign root     = res_r[NS-1];

endmodule

@@ hw/rtl/tfn_div.sv @@
// ---------------------------------------------------------------------------
// tfn_div
// Three pipelined restoring dividers with a rounding offset, one quotient bit per stage,
// then clamping, sign and zeroing of degenerate faces.
// ---------------------------------------------------------------------------
module tfn_div import tfn_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               vld_in,
  input  mag_t               m0, m1, m2,
  input  side_t              side_in,
  input  logic [ROOT_W-1:0]  root,
  output logic               vld_out,
  output logic [NORM_W-1:0]  n0, n1, n2,
  output logic               degen
);

  // Dividend (m << 30) + r/2 < 2^62, but the divisor shifted to the top
  // quotient bit needs up to 63 bits, so 64 bits keep it from wrapping.
  localparam int DW = 64;
  localparam int NS = QUO_W;

  logic [NS:0]          v_r;
  logic [DW-1:0]        num_r [NS+1][3];
  logic [QUO_W-1:0]     q_r   [NS+1][3];
  logic [ROOT_W-1:0]    d_r   [NS+1];
  side_t                sd_r  [NS+1];
  logic [DW-1:0]        sub   [NS][3];
  logic [NORM_W-1:0]    res   [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[NS-1:0], vld_in};
    end
  end

  always_comb begin
    for (int s = 0; s < NS; s++) begin
      for (int i = 0; i < 3; i++) begin
        sub[s][i] = DW'(d_r[s]) << (NS - 1 - s);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      num_r[0][0] <= (DW'(m0) << NORM_FRAC) + DW'(root >> 1);
      num_r[0][1] <= (DW'(m1) << NORM_FRAC) + DW'(root >> 1);
      num_r[0][2] <= (DW'(m2) << NORM_FRAC) + DW'(root >> 1);
      for (int i = 0; i < 3; i++) q_r[0][i] <= '0;
      d_r[0]  <= (root == '0) ? ROOT_W'(1) : root;
      sd_r[0] <= side_in;
      for (int s = 0; s < NS; s++) begin
        d_r[s+1]  <= d_r[s];
        sd_r[s+1] <= sd_r[s];
        for (int i = 0; i < 3; i++) begin
          if (num_r[s][i] >= sub[s][i]) begin
            num_r[s+1][i] <= num_r[s][i] - sub[s][i];
            q_r[s+1][i]   <= {q_r[s][i][QUO_W-2:0], 1'b1};
          end else begin
            num_r[s+1][i] <= num_r[s][i];
            q_r[s+1][i]   <= {q_r[s][i][QUO_W-2:0], 1'b0};
          end
        end
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      res[i] = (q_r[NS][i] > (QUO_W'(1) << NORM_FRAC)) ? (QUO_W'(1) << NORM_FRAC)
                                                       : q_r[NS][i];
      if (sd_r[NS].degen) res[i] = '0;
      else if (sd_r[NS].neg[i]) res[i] = -res[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_out <= 1'b0;
    end else if (en) begin
      vld_out <= v_r[NS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      n0    <= res[0];
      n1    <= res[1];
      n2    <= res[2];
      degen <= sd_r[NS].degen;
    end
  end

endmodule

@@ tb/sv/triangle_face_normal_unit_tb.sv @@
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// triangle_face_normal_unit_tb
// Drives triangles into the face normal pipeline with random bursts and
// output stalls, predicts each unit normal and checks every field in order.
// ---------------------------------------------------------------------------
module triangle_face_normal_unit_tb;

  localparam int CW = 32;
  localparam int PIPE_LAT = 73;

  typedef struct {
    logic signed [CW-1:0] v [9];
  } tri_t;

  typedef struct {
    logic signed [31:0] nx, ny, nz;
    logic               degen;
  } normal_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [CW-1:0] ax = '0, ay = '0, az = '0, bx = '0, by = '0, bz = '0;
  logic signed [CW-1:0] cx = '0, cy = '0, cz = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [31:0] out_nx, out_ny, out_nz;
  logic out_degen;

  tri_t    pending_tris [$];
  normal_t expected_normals [$];
  int      errors = 0;
  int      sent = 0, checked = 0, degen_seen = 0;
  bit      stim_done = 1'b0;

  triangle_face_normal_unit uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_vertex_a_x(ax), .in_vertex_a_y(ay), .in_vertex_a_z(az),
    .in_vertex_b_x(bx), .in_vertex_b_y(by), .in_vertex_b_z(bz),
    .in_vertex_c_x(cx), .in_vertex_c_y(cy), .in_vertex_c_z(cz),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_normal_x(out_nx), .out_normal_y(out_ny), .out_normal_z(out_nz),
    .out_degenerate(out_degen)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic logic [31:0] root_of(logic [63:0] s);
    logic [63:0] res;
    logic [63:0] b;
    res = 0;
    b = 64'd1 << 62;
    while (b > s) b = b >> 2;
    while (b != 0) begin
      if (s >= res + b) begin
        s = s - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res[31:0];
  endfunction

  function automatic normal_t face_normal(tri_t t);
    normal_t n;
    logic signed [CW:0] e1 [3];
    logic signed [CW:0] e2 [3];
    logic signed [127:0] cr [3];
    logic [127:0] mag [3];
    logic [63:0] m [3];
    logic [63:0] sum, r, q;
    logic [31:0] comp [3];
    int len;
    for (int i = 0; i < 3; i++) begin
      e1[i] = {t.v[3+i][CW-1], t.v[3+i]} - {t.v[i][CW-1], t.v[i]};
      e2[i] = {t.v[6+i][CW-1], t.v[6+i]} - {t.v[i][CW-1], t.v[i]};
    end
    cr[0] = 128'(e1[1]) * 128'(e2[2]) - 128'(e1[2]) * 128'(e2[1]);
    cr[1] = 128'(e1[2]) * 128'(e2[0]) - 128'(e1[0]) * 128'(e2[2]);
    cr[2] = 128'(e1[0]) * 128'(e2[1]) - 128'(e1[1]) * 128'(e2[0]);
    len = 0;
    for (int i = 0; i < 3; i++) begin
      mag[i] = cr[i] < 0 ? -cr[i] : cr[i];
      for (int k = 0; k < 128; k++) if (mag[i][k] && k + 1 > len) len = k + 1;
    end
    if (len == 0) begin
      n.nx = 0; n.ny = 0; n.nz = 0; n.degen = 1'b1;
      return n;
    end
    for (int i = 0; i < 3; i++)
      m[i] = len > 31 ? 64'(mag[i] >> (len - 31)) : 64'(mag[i] << (31 - len));
    sum = m[0] * m[0] + m[1] * m[1] + m[2] * m[2];
    r = 64'(root_of(sum));
    for (int i = 0; i < 3; i++) begin
      q = ((m[i] << 30) + (r >> 1)) / r;
      if (q > (64'd1 << 30)) q = 64'd1 << 30;
      if (cr[i] < 0) q = -q;
      comp[i] = q[31:0];
    end
    n.nx = comp[0]; n.ny = comp[1]; n.nz = comp[2]; n.degen = 1'b0;
    return n;
  endfunction

  function automatic logic [CW-1:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return 32'h8000_0000 + $urandom_range(0, 3);
      2: return 32'h7FFF_FFFF - $urandom_range(0, 3);
      default: return $signed(32'($urandom_range(0, 1 << 21))) - (1 << 20);
    endcase
  endfunction

  task automatic add_tri(logic [CW-1:0] a0, a1, a2, b0, b1, b2, c0, c1, c2);
    tri_t t;
    t.v = '{a0, a1, a2, b0, b1, b2, c0, c1, c2};
    pending_tris.push_back(t);
  endtask

  // Sender: bursts of random length separated by random gaps.
  int burst_left = 0, gap_left = 0;
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        expected_normals.push_back(face_normal(pending_tris.pop_front()));
        sent++;
      end
      if (!(in_valid && in_stall)) begin
        if (gap_left > 0 || pending_tris.size() == 0) begin
          in_valid <= 1'b0;
          if (gap_left > 0) gap_left--;
        end else begin
          in_valid <= 1'b1;
          {ax, ay, az} <= {pending_tris[0].v[0], pending_tris[0].v[1], pending_tris[0].v[2]};
          {bx, by, bz} <= {pending_tris[0].v[3], pending_tris[0].v[4], pending_tris[0].v[5]};
          {cx, cy, cz} <= {pending_tris[0].v[6], pending_tris[0].v[7], pending_tris[0].v[8]};
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
          end else begin
            burst_left--;
            if (burst_left == 0) gap_left = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 8);
          end
        end
      end
    end
  end

  // Receiver: stall pattern cycles through free-running, light and heavy stretches.
  int stall_phase = 0;
  always @(posedge clk) begin
    if (rst_n) begin
      stall_phase <= (stall_phase + 1) % 400;
      if (stall_phase < 100) out_stall <= 1'b0;
      else if (stall_phase < 250) out_stall <= ($urandom_range(0, 3) == 0);
      else out_stall <= ($urandom_range(0, 2) != 0);
      if (out_valid && !out_stall) begin
        if (expected_normals.size() == 0) begin
          $error("result with no request outstanding");
          errors++;
        end else begin
          normal_t e;
          e = expected_normals.pop_front();
          if (out_nx !== e.nx) begin
            $error("normal_x expected %0d got %0d", e.nx, out_nx); errors++;
          end
          if (out_ny !== e.ny) begin
            $error("normal_y expected %0d got %0d", e.ny, out_ny); errors++;
          end
          if (out_nz !== e.nz) begin
            $error("normal_z expected %0d got %0d", e.nz, out_nz); errors++;
          end
          if (out_degen !== e.degen) begin
            $error("degenerate expected %0b got %0b", e.degen, out_degen); errors++;
          end
          if (e.degen) degen_seen++;
          checked++;
        end
      end
    end
  end

  initial begin
    logic [CW-1:0] p, d;
    // Extremes, axis-aligned faces and both windings.
    add_tri(0, 0, 0, 0, 0, 0, 0, 0, 0);
    add_tri(0, 0, 0, 32'h10000, 0, 0, 0, 32'h10000, 0);
    add_tri(0, 0, 0, 0, 32'h10000, 0, 32'h10000, 0, 0);
    add_tri(0, 0, 0, 0, 32'h10000, 0, 0, 0, 32'h10000);
    add_tri(0, 0, 0, 0, 0, 32'h10000, 32'h10000, 0, 0);
    add_tri(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
            32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
    add_tri(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
            32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000);
    add_tri(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
            32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF);
    add_tri(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
            32'hFFFF_FFFF, 0, 32'hFFFF_FFFF);
    add_tri(0, 0, 0, 1, 0, 0, 0, 1, 0);
    add_tri(0, 0, 0, 1, 1, 1, 2, 2, 2);
    add_tri(5, 5, 5, 5, 5, 5, 9, 1, 3);
    add_tri(0, 0, 0, 1, 2, 3, 3, 1, 2);
    add_tri(32'h7FFF_FFFF, 0, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 0,
            0, 32'h8000_0000, 32'h7FFF_FFFF);
    add_tri(0, 0, 0, 32'h7FFF_FFFF, 1, 0, 32'h8000_0000, 32'hFFFF_FFFF, 0);
    for (int i = 0; i < 735; i++) begin
      case ($urandom_range(0, 9))
        0: begin
          // Collinear vertices give a degenerate face.
          p = rand_coord() >>> 2; d = $urandom_range(0, 3);
          add_tri(p, p + 1, p - 1, p + d, p + 1 + d, p - 1 + d,
                  p - d, p + 1 - d, p - 1 - d);
        end
        default: add_tri(rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                         rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                         rand_coord());
      endcase
    end
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    wait (pending_tris.size() == 0 && !(in_valid && in_stall));
    @(posedge clk);
    wait (expected_normals.size() == 0);
    repeat (PIPE_LAT + 20) @(posedge clk);
    $display("Sent %0d triangles, checked %0d normals, %0d of them degenerate.",
             sent, checked, degen_seen);
    if (errors == 0 && expected_normals.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
